@@ hdl/sha1md_pkg.sv @@
// Shared types, constants and helper functions of the SHA-1 digest engine.
`default_nettype none
package sha1md_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int ROUNDS      = 80;
	localparam int BLOCK_WORDS = 16;
	localparam int CHAIN_WORDS = 5;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] K_CH  = 32'h5A827999;
	localparam logic [31:0] K_PA1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
	localparam logic [31:0] K_PA2 = 32'hCA62C1D6;

	localparam logic [31:0] IV [CHAIN_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD1,
		ST_PAD2,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       is_end;
	} cmd_t;

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		return {x[30:0], x[31]};
	endfunction

	function automatic logic [31:0] rotl5(input logic [31:0] x);
		return {x[26:0], x[31:27]};
	endfunction

	function automatic logic [31:0] rotl30(input logic [31:0] x);
		return {x[1:0], x[31:2]};
	endfunction

endpackage
`default_nettype wire

@@ hdl/sha1_message_digest.sv @@
// Top level of the streaming SHA-1 engine: command queue in front, compression core behind.
// The core takes each byte or end mark while it is idle; every full 64-byte block adds a
// compression of 80 rounds and one chaining add, during which the core takes no commands.
// An end mark adds a padding step and one compression, two when the length needs an
// extra block; the digest words are then offered one by one on the result side.
// Reset is asynchronous: initial chaining words, zero byte count, command queue and output register empty.
`default_nettype none
module sha1_message_digest #(
	parameter int QUEUE_DEPTH = sha1md_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_present,
	input  wire logic        end_of_message,
	input  wire logic        push,
	output logic             full,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word,
	output logic             empty,
	input  wire logic        pop
);
	import sha1md_pkg::*;

	// Commands flow from the front queue to the core; the core pops one whenever it is
	// idle, so the front keeps taking words until it is full while a block is compressed.
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	sha1md_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.push           (push),
		.full           (full),
		.cmd            (cmd),
		.cmd_valid      (cmd_valid),
		.cmd_pop        (cmd_pop)
	);

	// The core holds the digest word in an output register, so the result side
	// stalls on its own while the front keeps filling.
	sha1md_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop),
		.empty       (empty),
		.pop         (pop),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule
`default_nettype wire

@@ hdl/sha1md_front.sv @@
// Input side: accepts words, drops empty ones and queues commands for the core.
`default_nettype none
module sha1md_front #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        data_byte,
	input  wire logic              byte_present,
	input  wire logic              end_of_message,
	input  wire logic              push,
	output logic                   full,
	output sha1md_pkg::cmd_t       cmd,
	output logic                   cmd_valid,
	input  wire logic              cmd_pop
);
	import sha1md_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             queue_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             enq;
	logic             deq;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	// A word with neither a byte nor an end mark changes nothing and is not queued.
	assign enq = push && !full && (byte_present || end_of_message);
	assign deq = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (enq) begin
			queue_q[wr_ptr_q] <= '{data: data_byte, has_byte: byte_present,
				is_end: end_of_message};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (deq && !enq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/sha1md_core.sv @@
// Back side: byte packing, padding, 80-round compression and digest output.
`default_nettype none
module sha1md_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha1md_pkg::cmd_t  cmd,
	input  wire logic              cmd_valid,
	output logic                   cmd_pop,
	output logic                   empty,
	input  wire logic              pop,
	output logic [31:0]            digest_word,
	output logic [2:0]             word_index,
	output logic                   last_word
);
	import sha1md_pkg::*;

	state_t      state_q, state_d;
	state_t      after_q, after_d;
	logic        start;
	logic        load_out;

	logic [31:0] chain_q [CHAIN_WORDS];
	logic [31:0] work_q  [CHAIN_WORDS];
	logic [31:0] win_q   [BLOCK_WORDS];
	logic [63:0] count_q;
	logic [6:0]  rnd_q;
	logic [2:0]  emit_q;

	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_idx_q;

	logic [5:0]  pos;
	logic [3:0]  widx;
	logic [1:0]  lane;
	logic [63:0] bit_len;
	logic [31:0] w, f, k, sum, w_next;

	assign pos     = count_q[5:0];
	assign widx    = pos[5:2];
	assign lane    = pos[1:0];
	assign bit_len = {count_q[60:0], 3'b000};

	// Round logic. During the rounds the window holds the current and next fifteen schedule words.
	always_comb begin
		w      = win_q[0];
		w_next = rotl1(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0]);
		if (rnd_q < 7'd20) begin
			f = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
			k = K_CH;
		end else if (rnd_q < 7'd40) begin
			f = work_q[1] ^ work_q[2] ^ work_q[3];
			k = K_PA1;
		end else if (rnd_q < 7'd60) begin
			f = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) | (work_q[2] & work_q[3]);
			k = K_MAJ;
		end else begin
			f = work_q[1] ^ work_q[2] ^ work_q[3];
			k = K_PA2;
		end
		sum = rotl5(work_q[0]) + f + work_q[4] + w + k;
	end

	always_comb begin
		state_d  = state_q;
		after_d  = after_q;
		start    = 1'b0;
		cmd_pop  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.has_byte && pos == 6'd63) begin
						start   = 1'b1;
						state_d = ST_ROUND;
						after_d = cmd.is_end ? ST_PAD1 : ST_IDLE;
					end else if (cmd.is_end) begin
						state_d = ST_PAD1;
					end
				end
			end
			ST_PAD1: begin
				start   = 1'b1;
				state_d = ST_ROUND;
				after_d = (pos >= 6'd56) ? ST_PAD2 : ST_EMIT;
			end
			ST_PAD2: begin
				start   = 1'b1;
				state_d = ST_ROUND;
				after_d = ST_EMIT;
			end
			ST_ROUND: begin
				if (rnd_q == 7'(ROUNDS - 1)) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = after_q;
			end
			ST_EMIT: begin
				load_out = !out_valid_q || pop;
				if (load_out && emit_q == 3'(CHAIN_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			after_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
			after_q <= after_d;
		end
	end

	// Block window: byte packing, padding and the rolling message schedule.
	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[BLOCK_WORDS - 1] <= w_next;
		end else if (state_q == ST_IDLE && cmd_pop && cmd.has_byte) begin
			if (lane == 2'd0) begin
				win_q[widx] <= {cmd.data, 24'h0};
			end else begin
				win_q[widx][{~lane, 3'b000} +: 8] <= cmd.data;
			end
		end else if (state_q == ST_PAD1) begin
			for (int i = 0; i < BLOCK_WORDS; i++) begin
				if (4'(i) > widx) begin
					win_q[i] <= '0;
				end
			end
			if (lane == 2'd0) begin
				win_q[widx] <= {PAD_MARK, 24'h0};
			end else begin
				win_q[widx][{~lane, 3'b000} +: 8] <= PAD_MARK;
			end
			// The length fits in this block when the mark lands before byte 56.
			if (pos < 6'd56) begin
				win_q[14] <= bit_len[63:32];
				win_q[15] <= bit_len[31:0];
			end
		end else if (state_q == ST_PAD2) begin
			for (int i = 0; i < BLOCK_WORDS - 2; i++) begin
				win_q[i] <= '0;
			end
			win_q[14] <= bit_len[63:32];
			win_q[15] <= bit_len[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				chain_q[i] <= IV[i];
				work_q[i]  <= '0;
			end
			count_q     <= '0;
			rnd_q       <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && cmd_pop && cmd.has_byte) begin
				count_q <= count_q + 64'd1;
			end
			if (start) begin
				for (int i = 0; i < CHAIN_WORDS; i++) begin
					work_q[i] <= chain_q[i];
				end
				rnd_q <= '0;
			end else if (state_q == ST_ROUND) begin
				work_q[0] <= sum;
				work_q[1] <= work_q[0];
				work_q[2] <= rotl30(work_q[1]);
				work_q[3] <= work_q[2];
				work_q[4] <= work_q[3];
				rnd_q     <= rnd_q + 7'd1;
			end
			if (state_q == ST_ADD) begin
				for (int i = 0; i < CHAIN_WORDS; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
				emit_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_word_q  <= chain_q[emit_q];
				out_idx_q   <= emit_q;
				emit_q      <= emit_q + 3'd1;
				// After the last word the next message starts from scratch.
				if (emit_q == 3'(CHAIN_WORDS - 1)) begin
					for (int i = 0; i < CHAIN_WORDS; i++) begin
						chain_q[i] <= IV[i];
					end
					count_q <= '0;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty       = !out_valid_q;
	assign digest_word = out_word_q;
	assign word_index  = out_idx_q;
	assign last_word   = (out_idx_q == 3'(CHAIN_WORDS - 1));

endmodule
`default_nettype wire
